[rtl/dip_pkg.sv]
// Package for the dotted IPv4 address parser: request and result payload
// types, parse state type and character constants. No dependencies.
package dip_pkg;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_DOT  = 8'h2E;

    localparam int unsigned RADIX      = 10;
    localparam int unsigned ACC_W      = 9;   // holds 0..256
    localparam int unsigned PROD_W     = 12;  // 256*10+9 fits
    localparam logic [ACC_W-1:0] OCTET_LIM = 9'd256;
    localparam logic [1:0] LAST_OCTET = 2'd3;

    typedef struct packed {
        logic [7:0] character;
        logic       first;
    } dip_in_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] address;
    } dip_out_t;

    typedef struct packed {
        logic             active;
        logic [1:0]       octet_index;
        logic [ACC_W-1:0] accumulator;
        logic [23:0]      done_octets;
    } dip_state_t;

endpackage

[rtl/dip_step.sv]
// One-character parse step: next parse state and optional result.
// Depends on dip_pkg.
module dip_step (
    input  dip_pkg::dip_state_t state_cur,
    input  dip_pkg::dip_in_t    item,
    output dip_pkg::dip_state_t state_next,
    output logic                emit,
    output dip_pkg::dip_out_t   result
);
    import dip_pkg::*;

    dip_state_t        st;
    logic              is_digit;
    logic [3:0]        digit;
    logic [PROD_W-1:0] prod;
    logic              too_big;

    always_comb begin
        st = state_cur;
        if (item.first) begin
            st = '{active: 1'b1, octet_index: 2'd0, accumulator: '0, done_octets: '0};
        end
        is_digit = (item.character >= CH_ZERO) && (item.character <= CH_NINE);
        digit    = 4'(item.character - CH_ZERO);
        prod     = PROD_W'(st.accumulator) * PROD_W'(RADIX) + PROD_W'(digit);
        too_big  = st.accumulator[ACC_W-1];   // only 256 sets the top bit

        state_next = st;
        emit       = 1'b0;
        result     = '{ok: 1'b0, address: '0};

        if (st.active) begin
            if (is_digit) begin
                state_next.accumulator = (prod >= PROD_W'(OCTET_LIM)) ? OCTET_LIM
                                                                       : ACC_W'(prod);
            end else if (st.octet_index == LAST_OCTET) begin
                emit              = 1'b1;
                state_next.active = 1'b0;
                if (!too_big) begin
                    result.ok      = 1'b1;
                    result.address = {st.accumulator[7:0], st.done_octets};
                end
            end else if (item.character == CH_DOT && !too_big) begin
                case (st.octet_index)
                    2'd0:    state_next.done_octets[7:0]   = st.accumulator[7:0];
                    2'd1:    state_next.done_octets[15:8]  = st.accumulator[7:0];
                    default: state_next.done_octets[23:16] = st.accumulator[7:0];
                endcase
                state_next.octet_index = st.octet_index + 2'd1;
                state_next.accumulator = '0;
            end else begin
                // bad character, or an oversized octet closed by a dot
                emit              = 1'b1;
                state_next.active = 1'b0;
            end
        end
    end

endmodule

[rtl/dotted_ipv4_address_parser.sv]
// Top level of the dotted IPv4 address parser: parse state register and
// result register around the dip_step logic. Depends on dip_pkg, dip_step.
//
// Usage:
//   Requests arrive on s_valid/s_ready/s_data, one host string character per
//   request; s_data.first marks the first character and restarts the parse.
//   Digits build the current octet (saturating at 256), dots close octets one
//   to three, and any non-digit in octet four closes the parse. One result
//   per string leaves on m_valid/m_ready/m_data: ok=1 with the address (first
//   octet in bits 7..0), or ok=0 with address zero. Characters after a result
//   and before the next first character are consumed and dropped.
//   Throughput: one request per cycle while no result waits for m_ready. The parse state is updated at the
//   accepting edge, so the next character can follow in the very next cycle.
//   Result: the result is in the output register in the cycle after the
//   request that closes the parse is accepted.
//   Stall: while a result waits for m_ready, s_ready stays high only if the
//   result is taken in the same cycle; otherwise input holds until it is.
//   Reset (aresetn low, synchronous): parse goes idle, no result is pending.
module dotted_ipv4_address_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dip_pkg::dip_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output dip_pkg::dip_out_t m_data
);
    import dip_pkg::*;

    dip_state_t state_reg;
    dip_state_t state_next;
    logic       step_emit;
    dip_out_t   step_result;
    logic       m_valid_reg;
    logic       m_valid_next;
    dip_out_t   m_data_reg;
    logic       s_accept;

    // Output slot is free when empty or being drained this cycle
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    dip_step u_step (
        .state_cur (state_reg),
        .item      (s_data),
        .state_next(state_next),
        .emit      (step_emit),
        .result    (step_result)
    );

    always_comb begin
        if (s_accept) begin
            m_valid_next = step_emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_accept) begin
                state_reg <= state_next;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept && step_emit) begin
            m_data_reg <= step_result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/dip_checker.sv]
// Port-level checks for the dotted IPv4 address parser, bound to the top
// level. Depends on dip_pkg and dotted_ipv4_address_parser.
module dip_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input dip_pkg::dip_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input dip_pkg::dip_out_t m_data
);
    import dip_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Failure carries a zero address
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.ok |-> m_data.address == 32'd0)
        else $error("failed parse with nonzero address");

    // A new result only follows an accepted request
    a_out_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
        else $error("result without request");

    // Taken result with no new request leaves the output empty
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !(s_valid && s_ready) |=> !m_valid)
        else $error("result repeated");

    // Input is never held off while the output slot is empty
    a_no_idle_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule

bind dotted_ipv4_address_parser dip_checker u_dip_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_data (s_data),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
